### rtl/lrtc_pkg.sv
// Package for the line result LRU tag cache.
// Holds the command codes, hash constants, the slot count and the queued command type.
// No dependencies.
package lrtc_pkg;

  localparam int SLOTS = 512;
  localparam logic [63:0] FNV_BASIS = 64'hCBF29CE484222325;
  localparam logic [63:0] FNV_PRIME = 64'h00000100000001B3;
  localparam logic [9:0] DEFAULT_LIMIT = 10'd512;

  typedef enum logic [1:0] {
    KIND_BYTE = 2'd0,
    KIND_LOOKUP = 2'd1,
    KIND_INV_RANGE = 2'd2,
    KIND_INV_ALL = 2'd3
  } kind_t;

  typedef struct packed {
    kind_t kind;
    logic [31:0] row_a;
    logic [31:0] row_b;
    logic [63:0] generation;
    logic [63:0] line_hash;
  } cmd_t;

endpackage

### rtl/lrtc_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module lrtc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### rtl/lrtc_front.sv
// Front end: accepts items, folds text bytes into the FNV-1a hash and
// queues lookups and invalidations for the back end. Uses lrtc_pkg.
module lrtc_front (
  input  logic               clk,
  input  logic               rst,
  input  logic               valid,
  output logic               stall,
  input  logic [1:0]         kind,
  input  logic [7:0]         text_byte,
  input  logic [31:0]        row_number,
  input  logic [31:0]        row_last,
  input  logic [63:0]        content_generation,
  output logic               q_valid,
  output lrtc_pkg::cmd_t     q_cmd,
  input  logic               q_pop
);

  logic [63:0] running_hash;
  logic [63:0] hash_xor;
  logic [63:0] hash_mul;
  logic        hash_pend;
  lrtc_pkg::cmd_t buf0, buf1;
  logic [1:0]  fill;
  logic        accept;
  logic        push;
  lrtc_pkg::cmd_t cmd_in;

  // A byte fold registers the xor first, then multiplies it into the running hash.
  assign stall = hash_pend || (fill == 2'd2);
  assign accept = valid && !stall;
  assign push = accept && (lrtc_pkg::kind_t'(kind) != lrtc_pkg::KIND_BYTE);
  // The FNV prime is 2^40 + 0x1B3, so the multiply reduces to shifted adds.
  assign hash_mul = (hash_xor << 40) + (hash_xor << 8) + (hash_xor << 7)
                  + (hash_xor << 5) + (hash_xor << 4) + (hash_xor << 1) + hash_xor;

  always_comb begin
    cmd_in.kind = lrtc_pkg::kind_t'(kind);
    cmd_in.row_a = row_number;
    cmd_in.row_b = row_last;
    cmd_in.generation = content_generation;
    cmd_in.line_hash = running_hash;
  end

  assign q_valid = (fill != 2'd0);
  assign q_cmd = buf0;

  always_ff @(posedge clk) begin
    if (rst) begin
      running_hash <= lrtc_pkg::FNV_BASIS;
      hash_pend <= 1'b0;
      fill <= 2'd0;
    end else begin
      if (hash_pend) begin
        running_hash <= hash_mul;
        hash_pend <= 1'b0;
      end else if (accept) begin
        if (lrtc_pkg::kind_t'(kind) == lrtc_pkg::KIND_BYTE) begin
          if (text_byte != 8'd0) begin
            hash_xor <= running_hash ^ {56'd0, text_byte};
            hash_pend <= 1'b1;
          end
        end else if (lrtc_pkg::kind_t'(kind) == lrtc_pkg::KIND_LOOKUP) begin
          running_hash <= lrtc_pkg::FNV_BASIS;
        end
      end
      unique case ({push, q_pop && q_valid})
        2'b10: begin
          if (fill == 2'd0) buf0 <= cmd_in;
          else buf1 <= cmd_in;
          fill <= fill + 2'd1;
        end
        2'b01: begin
          buf0 <= buf1;
          fill <= fill - 2'd1;
        end
        2'b11: begin
          if (fill == 2'd1) buf0 <= cmd_in;
          else begin
            buf0 <= buf1;
            buf1 <= cmd_in;
          end
        end
        default: ;
      endcase
    end
  end

  assert property (@(posedge clk) disable iff (rst) fill <= 2'd2)
    else $error("queue overfilled");
  assert property (@(posedge clk) disable iff (rst) hash_pend |=> !hash_pend)
    else $error("hash fold longer than two cycles");
  assert property (@(posedge clk) disable iff (rst) hash_pend |-> stall)
    else $error("accepted during hash fold");

endmodule

### rtl/lrtc_back.sv
// Back end: scans the slot store for each queued command, retags, evicts
// and invalidates. Uses lrtc_pkg and lrtc_ram for the tag fields.
module lrtc_back (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_we,
  input  logic [9:0]         cfg_data,
  input  logic               q_valid,
  input  lrtc_pkg::cmd_t     q_cmd,
  output logic               q_pop,
  output logic               out_valid,
  input  logic               out_stall,
  output logic               recomputed,
  output logic [8:0]         slot_index,
  output logic [9:0]         dropped_count,
  output logic [31:0]        dropped_row,
  output logic [9:0]         entry_count
);

  localparam int AW = (lrtc_pkg::SLOTS > 1) ? $clog2(lrtc_pkg::SLOTS) : 1;
  localparam int CW = $clog2(lrtc_pkg::SLOTS + 1);

  typedef enum logic [3:0] {
    S_IDLE, S_FIND, S_FREE, S_WRITE, S_VSCAN, S_VDROP, S_INV, S_OUT
  } state_t;

  state_t state;
  lrtc_pkg::cmd_t cmd;
  logic [9:0] entry_limit;
  logic [lrtc_pkg::SLOTS-1:0] valid_bits;
  logic [CW-1:0] valid_count;
  logic [63:0] use_tick;
  logic [AW:0] scan;
  logic [AW-1:0] at;
  logic found, need_full;
  logic [AW-1:0] victim;
  logic vfound;
  logic [63:0] vuse;
  logic [9:0] dropped;
  logic [31:0] drow;
  logic rec;
  logic rd_live;
  logic [AW-1:0] rd_addr, rd_q;

  logic we_tag, we_use;
  logic [AW-1:0] waddr;
  logic [31:0] row_rd;
  logic [63:0] gen_rd, hash_rd, use_rd;
  logic [31:0] wrow;
  logic [63:0] wuse;
  logic [CW-1:0] limit_eff;
  logic [10:0] limit_raw;
  logic [32:0] lo_k, hi_k, a_k, b_k, r_k;
  logic do_scan_step;

  lrtc_ram #(.WIDTH(32), .DEPTH(lrtc_pkg::SLOTS)) u_row (
    .clk, .we(we_tag && rec && !found), .waddr, .wdata(wrow), .raddr(rd_addr), .rdata(row_rd));
  lrtc_ram #(.WIDTH(64), .DEPTH(lrtc_pkg::SLOTS)) u_gen (
    .clk, .we(we_tag), .waddr, .wdata(cmd.generation), .raddr(rd_addr), .rdata(gen_rd));
  lrtc_ram #(.WIDTH(64), .DEPTH(lrtc_pkg::SLOTS)) u_hash (
    .clk, .we(we_tag), .waddr, .wdata(cmd.line_hash), .raddr(rd_addr), .rdata(hash_rd));
  lrtc_ram #(.WIDTH(64), .DEPTH(lrtc_pkg::SLOTS)) u_use (
    .clk, .we(we_use), .waddr, .wdata(wuse), .raddr(rd_addr), .rdata(use_rd));

  assign wrow = cmd.row_a;
  assign wuse = use_tick + 64'd1;
  assign waddr = at;
  assign we_tag = (state == S_WRITE) && rec;
  assign we_use = (state == S_WRITE);
  assign rd_addr = scan[AW-1:0];
  assign do_scan_step = (scan < (AW+1)'(lrtc_pkg::SLOTS));

  assign limit_raw = (entry_limit == 10'd0) ? 11'(lrtc_pkg::DEFAULT_LIMIT)
                                           : {1'b0, entry_limit};
  assign limit_eff = (limit_raw > 11'(lrtc_pkg::SLOTS)) ? CW'(lrtc_pkg::SLOTS)
                                                        : CW'(limit_raw);

  assign a_k = {1'b0, cmd.row_a ^ 32'h80000000};
  assign b_k = {1'b0, cmd.row_b ^ 32'h80000000};
  assign lo_k = (a_k < b_k) ? a_k : b_k;
  assign hi_k = (a_k < b_k) ? b_k : a_k;
  assign r_k = {1'b0, row_rd ^ 32'h80000000};

  assign q_pop = (state == S_IDLE) && q_valid;
  assign out_valid = (state == S_OUT);
  assign recomputed = rec;
  assign slot_index = 9'(at);
  assign dropped_count = dropped;
  assign dropped_row = drow;
  assign entry_count = 10'(valid_count);

  // Scans issue a read each cycle; rd_live marks data from the last address.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      entry_limit <= lrtc_pkg::DEFAULT_LIMIT;
      valid_bits <= '0;
      valid_count <= '0;
      use_tick <= '0;
      rd_live <= 1'b0;
    end else begin
      if (cfg_we) entry_limit <= cfg_data;
      rd_q <= rd_addr;
      unique case (state)
        S_IDLE: begin
          rd_live <= 1'b0;
          if (q_valid) begin
            cmd <= q_cmd;
            scan <= '0;
            found <= 1'b0;
            at <= '0;
            rec <= 1'b0;
            dropped <= '0;
            drow <= '0;
            unique case (q_cmd.kind)
              lrtc_pkg::KIND_LOOKUP: state <= S_FIND;
              lrtc_pkg::KIND_INV_RANGE: state <= S_INV;
              lrtc_pkg::KIND_INV_ALL: begin
                dropped <= 10'(valid_count);
                valid_bits <= '0;
                valid_count <= '0;
                state <= S_OUT;
              end
              default: state <= S_IDLE;
            endcase
          end
        end
        S_FIND: begin
          if (do_scan_step) scan <= scan + 1'b1;
          rd_live <= do_scan_step;
          if (rd_live && !found && valid_bits[rd_q] && row_rd == cmd.row_a) begin
            found <= 1'b1;
            at <= rd_q;
            rec <= !(gen_rd == cmd.generation && hash_rd == cmd.line_hash);
          end
          if (!do_scan_step && !rd_live) begin
            if (found) state <= S_WRITE;
            else begin
              rec <= 1'b1;
              state <= S_FREE;
            end
          end
        end
        S_FREE: begin
          if (&valid_bits) begin
            need_full <= 1'b1;
            scan <= '0;
            vfound <= 1'b0;
            rd_live <= 1'b0;
            state <= S_VSCAN;
          end else begin
            for (int i = lrtc_pkg::SLOTS - 1; i >= 0; i--) begin
              if (!valid_bits[i]) at <= AW'(i);
            end
            state <= S_WRITE;
          end
        end
        S_WRITE: begin
          use_tick <= wuse;
          if (rec && !found) begin
            valid_bits[at] <= 1'b1;
            valid_count <= valid_count + 1'b1;
          end
          need_full <= 1'b0;
          scan <= '0;
          vfound <= 1'b0;
          rd_live <= 1'b0;
          if (rec && (valid_count + CW'(!found)) > limit_eff) state <= S_VSCAN;
          else state <= S_OUT;
        end
        S_VSCAN: begin
          if (do_scan_step) scan <= scan + 1'b1;
          rd_live <= do_scan_step;
          if (rd_live && valid_bits[rd_q] && (need_full || rd_q != at)
              && (!vfound || use_rd < vuse)) begin
            vfound <= 1'b1;
            victim <= rd_q;
            vuse <= use_rd;
            drow <= row_rd;
          end
          if (!do_scan_step && !rd_live) state <= S_VDROP;
        end
        S_VDROP: begin
          if (!vfound) state <= S_OUT;
          else begin
            valid_bits[victim] <= 1'b0;
            valid_count <= valid_count - 1'b1;
            dropped <= dropped + 10'd1;
            if (need_full) begin
              at <= victim;
              state <= S_WRITE;
            end else if ((valid_count - 1'b1) > limit_eff) begin
              scan <= '0;
              vfound <= 1'b0;
              rd_live <= 1'b0;
              state <= S_VSCAN;
            end else state <= S_OUT;
          end
        end
        S_INV: begin
          if (do_scan_step) scan <= scan + 1'b1;
          rd_live <= do_scan_step;
          if (rd_live && valid_bits[rd_q] && r_k >= lo_k && r_k <= hi_k) begin
            valid_bits[rd_q] <= 1'b0;
            valid_count <= valid_count - 1'b1;
            dropped <= dropped + 10'd1;
          end
          if (!do_scan_step && !rd_live) state <= S_OUT;
        end
        S_OUT: begin
          if (!out_stall) state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assert property (@(posedge clk) disable iff (rst) valid_count <= CW'(lrtc_pkg::SLOTS))
    else $error("valid count above slot count");
  assert property (@(posedge clk) disable iff (rst)
    (state == S_OUT && out_stall) |=> (state == S_OUT && $stable(dropped)))
    else $error("result changed while stalled");
  assert property (@(posedge clk) disable iff (rst)
    q_pop |=> state != S_IDLE || !$past(q_cmd.kind != lrtc_pkg::KIND_BYTE))
    else $error("command lost");

endmodule

### rtl/line_result_lru_tag_cache.sv
// Top level of the line result LRU tag cache.
// Joins lrtc_front and lrtc_back; uses lrtc_pkg.
//
// Usage: items enter on valid/stall with kind, text_byte, row_number,
// row_last and content_generation. A text byte gives no word out; a
// nonzero byte folds into the FNV-1a hash; the xor is registered before
// the prime multiply. Lookups and invalidations enter a two-deep queue
// and give one output word each on out_valid/out_stall. A lookup scans
// the slot store once, then each LRU victim search is another scan; a
// range invalidation is one scan; whole invalidation needs no scan. The
// scans read one slot a cycle through the tag RAM read port.
// While out_stall is high the result word holds and the queue fills;
// the front stalls once it is full. Reset clears the valid bits, count,
// tick and hash at once, with no clearing pass. cfg_we writes entry_limit.
module line_result_lru_tag_cache (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [9:0]  cfg_data,
  input  logic        valid,
  output logic        stall,
  input  logic [1:0]  kind,
  input  logic [7:0]  text_byte,
  input  logic signed [31:0] row_number,
  input  logic signed [31:0] row_last,
  input  logic [63:0] content_generation,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        recomputed,
  output logic [8:0]  slot_index,
  output logic [9:0]  dropped_count,
  output logic signed [31:0] dropped_row,
  output logic [9:0]  entry_count
);

  logic q_valid, q_pop;
  lrtc_pkg::cmd_t q_cmd;

  lrtc_front u_front (
    .clk, .rst, .valid, .stall, .kind, .text_byte,
    .row_number(row_number), .row_last(row_last), .content_generation,
    .q_valid, .q_cmd, .q_pop);

  lrtc_back u_back (
    .clk, .rst, .cfg_we, .cfg_data, .q_valid, .q_cmd, .q_pop,
    .out_valid, .out_stall, .recomputed, .slot_index, .dropped_count,
    .dropped_row, .entry_count);

endmodule
